### hdl/ngfs_pkg.sv
// Shared constants and helpers for the n-gram fitness scorer.
// No dependencies; imported by the top level and the testbench.
package ngfs_pkg;

	// Default table depth and fixed-point scale
	localparam int DEF_TABLE_DEPTH   = 524288;
	localparam int DEF_FRACTION_BITS = 10;

	// Field widths
	localparam int SYM_W   = 5;
	localparam int INDEX_W = 19;
	localparam int VALUE_W = 16;
	localparam int SCORE_W = 32;
	localparam int LEN_W   = 3;

	// Lookup index width: holds the largest base-26 sum of 5-bit symbols
	localparam int IDX_W = 20;

	// Symbol coding and base-26 place weights
	localparam logic [SYM_W-1:0] SEPARATOR = 5'd26;
	localparam int RADIX1 = 26;
	localparam int RADIX2 = 676;
	localparam int RADIX3 = 17576;

	// Legal n-gram lengths
	localparam logic [LEN_W-1:0] LEN_MIN = 3'd2;
	localparam logic [LEN_W-1:0] LEN_MID = 3'd3;
	localparam logic [LEN_W-1:0] LEN_MAX = 3'd4;

	// Separator penalties before scaling
	localparam int PEN_LEN2 = 9;
	localparam int PEN_LEN3 = 10;
	localparam int PEN_LEN4 = 13;

	// Register map (word index)
	localparam logic REG_GRAM_LENGTH = 1'b0;

	// Scaled separator penalty for an effective length
	function automatic logic [SCORE_W-1:0] penalty(input logic [LEN_W-1:0] len,
			input int frac);
		logic [SCORE_W-1:0] base;
		case (len)
			LEN_MIN: base = SCORE_W'(PEN_LEN2);
			LEN_MID: base = SCORE_W'(PEN_LEN3);
			default: base = SCORE_W'(PEN_LEN4);
		endcase
		return base << frac;
	endfunction

endpackage

### hdl/ngram_fitness_scorer.sv
// Top level of the n-gram fitness scorer: window tracking, table lookup,
// saturating accumulator and APB register. Uses ngfs_pkg and ngfs_ram.
//
// Channel | Dir | Handshake             | Beat contents
// --------+-----+-----------------------+--------------------------------------
// in      | in  | in_valid / in_stall   | action, table_index, table_value,
//         |     |                       | symbol, last
// out     | out | out_valid / out_stall | score (one beat per text)
// apb     | in  | psel, penable, pready | gram_length at byte address 0
//
// One beat is taken every cycle while in_stall is low. A load beat writes
// the table at its accept edge. A text beat reads the table at its accept
// edge and is accumulated from the registered read data in stage 1; a final
// beat then loads the result register that drives out. in_stall rises only
// while a final beat waits behind a stalled out beat. arst_n clears the
// window, count, total and gram_length (to 4); the table is not cleared.
module ngram_fitness_scorer
	import ngfs_pkg::*;
#(
	parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      action,
	input  logic [INDEX_W-1:0]        table_index,
	input  logic signed [VALUE_W-1:0] table_value,
	input  logic [SYM_W-1:0]          symbol,
	input  logic                      last,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [SCORE_W-1:0] score,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	localparam int AW = $clog2(TABLE_DEPTH);

	// Configuration
	logic [LEN_W-1:0] gram_length_q;

	// Window history
	logic [SYM_W-1:0] recent_q [3];
	logic [1:0]       seen_q;

	// Stage 1: lookup in flight
	logic             valid_s1;
	logic             last_s1;
	logic             active_s1;
	logic             sep_s1;
	logic             in_range_s1;
	logic [LEN_W-1:0] len_s1;

	// Accumulator and result register
	logic signed [SCORE_W-1:0] total_q;
	logic                      out_valid_q;
	logic signed [SCORE_W-1:0] score_q;

	// Handshake and datapath nets
	logic accept, text_acc, load_acc;
	logic s1_block, s1_fire;
	logic [LEN_W-1:0] eff_len;
	logic             win_active, win_sep, lookup_in_range, load_in_range;
	logic [IDX_W-1:0] lookup_idx, t1, t2, t3;
	logic [2:0]       rec_sep;
	logic             sym_sep;
	logic signed [VALUE_W-1:0] table_rd;
	logic signed [SCORE_W:0]   delta, sum;
	logic signed [SCORE_W-1:0] sat_sum, next_total;

	// APB register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_GRAM_LENGTH) ? {29'd0, gram_length_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gram_length_q <= LEN_MAX;
		end else if (psel && penable && pwrite && pready &&
				paddr[2] == REG_GRAM_LENGTH) begin
			gram_length_q <= pwdata[LEN_W-1:0];
		end
	end

	// Flow control: stall only when a final beat cannot reach the result register
	assign s1_block = last_s1 && out_valid_q && out_stall;
	assign s1_fire  = valid_s1 && !s1_block;
	assign in_stall = valid_s1 && s1_block;
	assign accept   = in_valid && !in_stall;
	assign text_acc = accept && action;
	assign load_acc = accept && !action;

	// Clamp the configured length into 2..4
	always_comb begin
		if (gram_length_q < LEN_MIN) begin
			eff_len = LEN_MIN;
		end else if (gram_length_q > LEN_MAX) begin
			eff_len = LEN_MAX;
		end else begin
			eff_len = gram_length_q;
		end
	end

	// Form the window's base-26 index and separator flag
	always_comb begin
		sym_sep = symbol >= SEPARATOR;
		for (int i = 0; i < 3; i++) begin
			rec_sep[i] = recent_q[i] >= SEPARATOR;
		end
		t1 = IDX_W'(recent_q[0]) * IDX_W'(RADIX1);
		t2 = IDX_W'(recent_q[1]) * IDX_W'(RADIX2);
		t3 = IDX_W'(recent_q[2]) * IDX_W'(RADIX3);
		case (eff_len)
			LEN_MIN: begin
				win_active = seen_q >= 2'd1;
				win_sep    = sym_sep || rec_sep[0];
				lookup_idx = IDX_W'(symbol) + t1;
			end
			LEN_MID: begin
				win_active = seen_q >= 2'd2;
				win_sep    = sym_sep || rec_sep[0] || rec_sep[1];
				lookup_idx = IDX_W'(symbol) + t1 + t2;
			end
			default: begin
				win_active = seen_q == 2'd3;
				win_sep    = sym_sep || rec_sep[0] || rec_sep[1] || rec_sep[2];
				lookup_idx = IDX_W'(symbol) + t1 + t2 + t3;
			end
		endcase
		lookup_in_range = lookup_idx < IDX_W'(TABLE_DEPTH);
		load_in_range   = {1'b0, table_index} < IDX_W'(TABLE_DEPTH);
	end

	// N-gram table
	ngfs_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (load_acc && load_in_range),
		.waddr(table_index[AW-1:0]),
		.wdata(table_value),
		.re   (text_acc),
		.raddr(lookup_idx[AW-1:0]),
		.rdata(table_rd)
	);

	// Advance the window history on each text beat; clear it after a final beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				recent_q[i] <= '0;
			end
			seen_q <= '0;
		end else if (text_acc) begin
			if (last) begin
				for (int i = 0; i < 3; i++) begin
					recent_q[i] <= '0;
				end
				seen_q <= '0;
			end else begin
				recent_q[2] <= recent_q[1];
				recent_q[1] <= recent_q[0];
				recent_q[0] <= symbol;
				if (seen_q != 2'd3) begin
					seen_q <= seen_q + 2'd1;
				end
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (text_acc) begin
			last_s1     <= last;
			active_s1   <= win_active;
			sep_s1      <= win_sep;
			in_range_s1 <= lookup_in_range;
			len_s1      <= eff_len;
		end
	end

	// Saturating add of the table value or subtract of the penalty; out-of-range lookups add zero
	always_comb begin
		if (sep_s1) begin
			delta = -$signed({1'b0, penalty(len_s1, FRACTION_BITS)});
		end else if (in_range_s1) begin
			delta = (SCORE_W+1)'(table_rd);
		end else begin
			delta = '0;
		end
		sum = (SCORE_W+1)'(total_q) + delta;
		if (sum[SCORE_W] != sum[SCORE_W-1]) begin
			sat_sum = sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}}
				: {1'b0, {(SCORE_W-1){1'b1}}};
		end else begin
			sat_sum = sum[SCORE_W-1:0];
		end
		next_total = active_s1 ? sat_sum : total_q;
	end

	// Accumulator and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_fire) begin
				total_q <= last_s1 ? '0 : next_total;
			end
			if (s1_fire && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			score_q <= next_total;
		end
	end

	assign out_valid = out_valid_q;
	assign score     = score_q;

endmodule

### hdl/ngfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the n-gram log-probability table.
module ngfs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port; read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/ngfs_checker.sv
// Port-level checks for the n-gram fitness scorer, bound to its top level.
// Uses only top-level ports; no package dependency.
module ngfs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        action,
	input logic        last,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] score,
	input logic        pready
);

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(score))
		else $error("stalled score beat changed");

	// Raise out_valid only after an accepted final text beat
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && action && last, 2))
		else $error("score beat without a final text beat");

	// Stall input only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with output free");

	// Complete every register access at once
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind ngram_fitness_scorer ngfs_checker u_ngfs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.action   (action),
	.last     (last),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.score    (score),
	.pready   (pready)
);

### tb/sv/testbench.sv
// Self-checking testbench for ngram_fitness_scorer: load and text beats, APB
// writes of gram_length, and a score predictor that checks every out beat.
// Depends on ngfs_pkg and the ngram_fitness_scorer RTL.
`timescale 1ns / 100ps

module testbench;
	import ngfs_pkg::*;

	// Beat actions and symbols used by name
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TEXT = 1'b1;
	localparam logic [SYM_W-1:0] SYM_A = 5'd0;
	localparam logic [SYM_W-1:0] SYM_Z = 5'd25;
	localparam logic [SYM_W-1:0] SYM_TOP = 5'd31;
	localparam logic [SYM_W-1:0] SYM_ABOVE = 5'd27;

	// Register addresses: gram_length, and the first word past the map
	localparam logic [2:0] ADDR_GRAM_LENGTH = {REG_GRAM_LENGTH, 2'b00};
	localparam logic [2:0] ADDR_PAST_MAP = 3'd4;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int LATENCY_SETTLE = 4;
	localparam int END_SETTLE = 8;
	localparam int MAX_PRINTS = 40;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 44;
	localparam int ROWS = 25;
	localparam logic [LEN_W-1:0] PHASE_LEN [RANDOM_PHASES] =
		'{3'd2, 3'd3, 3'd4, 3'd0, 3'd7, 3'd3, 3'd5, 3'd1};

	typedef logic [2:0][SYM_W-1:0] hist_t;

	typedef struct packed {
		logic act;
		logic [INDEX_W-1:0] idx;
		logic signed [VALUE_W-1:0] val;
		logic [SYM_W-1:0] sym;
		logic lst;
		logic typed;
		logic signed [SCORE_W-1:0] want;
	} beat_row_t;

	// Directed beats at the reset length of 4
	localparam beat_row_t DIRECTED [ROWS] = '{
		// table extremes: AAAA max, ZZZZ min, top index never read
		'{ACT_LOAD, 19'd0, 16'sh7FFF, SYM_A, 1'b0, 1'b0, 32'sd0},
		'{ACT_LOAD, 19'd456975, 16'sh8000, SYM_TOP, 1'b0, 1'b0, 32'sd0},
		'{ACT_LOAD, 19'h7FFFF, 16'sh1234, SEPARATOR, 1'b1, 1'b0, 32'sd0},
		// short text scores zero
		'{ACT_TEXT, 19'd0, 16'sd0, SYM_A, 1'b1, 1'b1, 32'sd0},
		// one full window of AAAA
		'{ACT_TEXT, 19'd0, 16'sd0, SYM_A, 1'b0, 1'b0, 32'sd0},
		'{ACT_TEXT, 19'd0, 16'sd0, SYM_A, 1'b0, 1'b0, 32'sd0},
		'{ACT_TEXT, 19'd0, 16'sd0, SYM_A, 1'b0, 1'b0, 32'sd0},
		'{ACT_TEXT, 19'd0, 16'sd0, SYM_A, 1'b1, 1'b1, 32'sd32767},
		// one full window of ZZZZ
		'{ACT_TEXT, 19'h7FFFF, 16'shFFFF, SYM_Z, 1'b0, 1'b0, 32'sd0},
		'{ACT_TEXT, 19'h7FFFF, 16'shFFFF, SYM_Z, 1'b0, 1'b0, 32'sd0},
		'{ACT_TEXT, 19'h7FFFF, 16'shFFFF, SYM_Z, 1'b0, 1'b0, 32'sd0},
		'{ACT_TEXT, 19'h7FFFF, 16'shFFFF, SYM_Z, 1'b1, 1'b1, -32'sd32768},
		// separator in the window costs the length-4 penalty
		'{ACT_TEXT, 19'd0, 16'sd0, SYM_A, 1'b0, 1'b0, 32'sd0},
		'{ACT_TEXT, 19'd0, 16'sd0, SYM_A, 1'b0, 1'b0, 32'sd0},
		'{ACT_TEXT, 19'd0, 16'sd0, SYM_A, 1'b0, 1'b0, 32'sd0},
		'{ACT_TEXT, 19'd0, 16'sd0, SEPARATOR, 1'b1, 1'b1, -32'sd13312},
		// symbols above range act as separators
		'{ACT_TEXT, 19'd0, 16'sd0, SYM_TOP, 1'b0, 1'b0, 32'sd0},
		'{ACT_TEXT, 19'd0, 16'sd0, SYM_TOP, 1'b0, 1'b0, 32'sd0},
		'{ACT_TEXT, 19'd0, 16'sd0, SYM_TOP, 1'b0, 1'b0, 32'sd0},
		'{ACT_TEXT, 19'd0, 16'sd0, SYM_TOP, 1'b1, 1'b1, -32'sd13312},
		// load inside a text leaves the window alone
		'{ACT_TEXT, 19'd0, 16'sd0, SYM_A, 1'b0, 1'b0, 32'sd0},
		'{ACT_TEXT, 19'd0, 16'sd0, SYM_A, 1'b0, 1'b0, 32'sd0},
		'{ACT_LOAD, 19'd1, 16'sd5, SEPARATOR, 1'b1, 1'b0, 32'sd0},
		'{ACT_TEXT, 19'd0, 16'sd0, SYM_A, 1'b0, 1'b0, 32'sd0},
		'{ACT_TEXT, 19'd0, 16'sd0, SYM_A, 1'b1, 1'b1, 32'sd32767}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic action;
	logic [INDEX_W-1:0] table_index;
	logic signed [VALUE_W-1:0] table_value;
	logic [SYM_W-1:0] symbol;
	logic last;
	logic out_valid;
	logic out_stall;
	logic signed [SCORE_W-1:0] score;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// Tag that rides with each in beat: typed-in score for directed rows
	logic tag_typed;
	logic signed [SCORE_W-1:0] tag_score;

	// Predictor state, advanced on accepted beats
	logic [LEN_W-1:0] len_reg = LEN_MAX;
	hist_t text_hist = '0;
	int text_seen = 0;
	logic signed [SCORE_W-1:0] text_total = '0;
	logic signed [VALUE_W-1:0] table_copy [int unsigned];
	logic signed [SCORE_W-1:0] expected_scores [$];

	// Stimulus-side view of the window, to keep lookups on loaded entries
	hist_t plan_hist = '0;
	int plan_seen = 0;
	bit table_loaded [int unsigned];

	bit idle_on = 1'b1;
	bit stall_on = 1'b1;
	int stall_left = 0;
	int fail_count = 0;
	int cycle_count = 0;

	ngram_fitness_scorer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.table_index(table_index),
		.table_value(table_value),
		.symbol(symbol),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.score(score),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int eff_len(input logic [LEN_W-1:0] g);
		if (g < LEN_MIN) return int'(LEN_MIN);
		if (g > LEN_MAX) return int'(LEN_MAX);
		return int'(g);
	endfunction

	// True when the window is complete and all letters; idx is its base-26 value
	function automatic logic window_letters(input hist_t hist, input int seen,
			input int n, input logic [SYM_W-1:0] sym, output int unsigned idx);
		int unsigned weight;
		logic letters;
		letters = (seen >= n - 1) && (sym < SEPARATOR);
		idx = sym;
		weight = RADIX1;
		for (int k = 0; k < n - 1; k++) begin
			if (hist[k] >= SEPARATOR) letters = 1'b0;
			else idx += hist[k] * weight;
			weight *= RADIX1;
		end
		return letters;
	endfunction

	function automatic longint separator_cost(input int n);
		longint base;
		case (n)
			2: base = PEN_LEN2;
			3: base = PEN_LEN3;
			default: base = PEN_LEN4;
		endcase
		return base << DEF_FRACTION_BITS;
	endfunction

	function automatic logic signed [SCORE_W-1:0] saturate(input longint t);
		if (t > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (t < -64'sd2147483648) return 32'sh80000000;
		return SCORE_W'(t);
	endfunction

	// Mostly short pauses, a few long ones
	function automatic int draw_pause();
		int r;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	// Small letter pool keeps table entries reused; the rest spans every code
	function automatic logic [SYM_W-1:0] pick_symbol();
		int r;
		r = $urandom_range(99);
		if (r < 45) return SYM_W'($urandom_range(2));
		if (r < 60) return SYM_Z;
		if (r < 80) return SYM_W'($urandom_range(25));
		if (r < 92) return SEPARATOR;
		return SYM_W'($urandom_range(int'(SYM_ABOVE), int'(SYM_TOP)));
	endfunction

	task automatic report_mismatch(input string msg);
		if (fail_count < MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
		fail_count++;
	endtask

	// One APB transfer; entered and left just after a rising edge
	task automatic apb_xfer(input logic wr, input logic [2:0] addr,
			input logic [31:0] data, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_gram_length();
		logic [31:0] rd;
		apb_xfer(1'b0, ADDR_GRAM_LENGTH, '0, rd);
		if (rd !== 32'(len_reg))
			report_mismatch($sformatf("gram_length read %0d, expected %0d", rd, len_reg));
	endtask

	// Write gram_length with junk in the upper bits, then read it back
	task automatic set_gram_length(input logic [LEN_W-1:0] value);
		logic [31:0] rd;
		apb_xfer(1'b1, ADDR_GRAM_LENGTH, {29'($urandom), value}, rd);
		len_reg = value;
		check_gram_length();
	endtask

	// Drop valid and wait for every score, then let the pipeline drain
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_scores.size() != 0);
		repeat (LATENCY_SETTLE) @(posedge clk);
	endtask

	// Send one beat; entered and left just after a rising edge
	task automatic send_item(input logic act, input logic [INDEX_W-1:0] idx,
			input logic signed [VALUE_W-1:0] val, input logic [SYM_W-1:0] sym,
			input logic lst, input logic typed, input logic signed [SCORE_W-1:0] want);
		int gap;
		gap = idle_on ? draw_pause() : 0;
		if (act == ACT_LOAD) begin
			table_loaded[idx] = 1'b1;
		end else if (lst) begin
			plan_hist = '0;
			plan_seen = 0;
		end else begin
			plan_hist = {plan_hist[1:0], sym};
			if (plan_seen < 3) plan_seen++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		table_index <= idx;
		table_value <= val;
		symbol <= sym;
		last <= lst;
		tag_typed <= typed;
		tag_score <= want;
		do @(posedge clk); while (in_stall);
	endtask

	// Text beat, preceded by a load when its window would hit an unloaded entry
	task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic lst);
		int unsigned idx;
		if (window_letters(plan_hist, plan_seen, eff_len(len_reg), sym, idx)
				&& !table_loaded.exists(idx))
			send_item(ACT_LOAD, INDEX_W'(idx), VALUE_W'($urandom), SYM_W'($urandom),
				1'($urandom), 1'b0, '0);
		send_item(ACT_TEXT, INDEX_W'($urandom), VALUE_W'($urandom), sym, lst,
			1'b0, '0);
	endtask

	task automatic send_noise_load();
		send_item(ACT_LOAD, INDEX_W'($urandom), VALUE_W'($urandom), SYM_W'($urandom),
			1'($urandom), 1'b0, '0);
	endtask

	// Predict: apply each accepted beat to the shadow table and window
	always @(posedge clk) begin : predict_scores
		int n;
		int unsigned idx;
		longint delta;
		if (arst_n && in_valid && !in_stall) begin
			if (action == ACT_LOAD) begin
				table_copy[table_index] = table_value;
			end else begin
				n = eff_len(len_reg);
				if (text_seen >= n - 1) begin
					if (window_letters(text_hist, text_seen, n, symbol, idx))
						delta = table_copy.exists(idx) ? longint'(table_copy[idx]) : 0;
					else
						delta = -separator_cost(n);
					text_total = saturate(longint'(text_total) + delta);
				end
				text_hist = {text_hist[1:0], symbol};
				if (text_seen < 3) text_seen++;
				if (last) begin
					expected_scores.push_back(tag_typed ? tag_score : text_total);
					text_hist = '0;
					text_seen = 0;
					text_total = '0;
				end
			end
		end
	end

	// Check each out beat against the oldest expected score
	always @(posedge clk) begin : check_scores
		logic signed [SCORE_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_scores.size() == 0) begin
				report_mismatch($sformatf("score %0d with none expected", score));
			end else begin
				want = expected_scores.pop_front();
				if (score !== want)
					report_mismatch($sformatf("score %0d, expected %0d", score, want));
			end
		end
	end

	// Random out stalls: mostly short bursts, a few long ones
	always @(posedge clk) begin : drive_out_stall
		int r;
		if (!stall_on) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			r = $urandom_range(99);
			if (r < 70) begin
				out_stall <= 1'b0;
			end else begin
				stall_left = (r < 93) ? $urandom_range(2) : $urandom_range(4, 24);
				out_stall <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : stimulus
		int sent;
		int text_len;
		bit drop_last;
		logic [31:0] rd;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_LOAD;
		table_index = '0;
		table_value = '0;
		symbol = '0;
		last = 1'b0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tag_typed = 1'b0;
		tag_score = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset value of gram_length, then the directed rows
		check_gram_length();
		for (int i = 0; i < ROWS; i++)
			send_item(DIRECTED[i].act, DIRECTED[i].idx, DIRECTED[i].val, DIRECTED[i].sym,
				DIRECTED[i].lst, DIRECTED[i].typed, DIRECTED[i].want);

		// Random phases, one gram_length setting each; texts may run across
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_idle();
			set_gram_length(PHASE_LEN[p]);
			if (p == 5) begin
				apb_xfer(1'b1, ADDR_PAST_MAP, $urandom, rd);
				check_gram_length();
			end
			idle_on = (p != 2);
			stall_on = (p != 2);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(99) < 10) begin
					send_noise_load();
					sent++;
				end else begin
					text_len = ($urandom_range(99) < 85) ? $urandom_range(1, 10)
						: $urandom_range(11, 24);
					drop_last = ($urandom_range(99) < 8);
					for (int i = 0; i < text_len; i++) begin
						send_symbol(pick_symbol(), !drop_last && i == text_len - 1);
						sent++;
					end
				end
			end
		end

		wait_idle();
		repeat (END_SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
